FILE: hdl/gtpvc_pkg.sv
package gtpvc_pkg;

    localparam int CORDIC_STEPS_DEF   = 16;
    localparam int SIG_DEPTH_DEF      = 256;
    localparam int SQRT_STEPS         = 17;
    localparam int ANG_PI             = 12868;
    localparam int ANG_2PI            = 25736;
    localparam int ANG_HALF_PI        = 6434;
    localparam int TURN_CAP           = 4915;
    localparam int TURN_DEADBAND      = 819;
    localparam int CORDIC_GAIN_INV    = 652032874;
    localparam longint EXP_M1_Q30     = 395007542;
    localparam int CFG_INDEX_W        = 4;
    localparam int CFG_DATA_W         = 15;

    typedef enum logic [1:0] {
        MODE_DRIVE = 2'd0,
        MODE_TURN  = 2'd1,
        MODE_STOP  = 2'd2
    } drive_mode_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_STOP_DISTANCE = 4'd0,
        REG_SPEED_LIMIT   = 4'd1
    } cfg_reg_t;

    // floor(atan(2^-k) * 2^30)
    localparam logic [31:0] ATAN_Q30 [24] = '{
        32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158, 32'd67021686,
        32'd33543515, 32'd16775850, 32'd8388437, 32'd4194282, 32'd2097149,
        32'd1048575, 32'd524287, 32'd262143, 32'd131071, 32'd65535, 32'd32767,
        32'd16383, 32'd8191, 32'd4095, 32'd2047, 32'd1023, 32'd511, 32'd255, 32'd127
    };

    // Restoring long division, used only while building constant tables.
    function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--)
        begin
            r = {r[63:0], num[b]};
            if (r >= {1'b0, den})
            begin
                r = r - {1'b0, den};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // Sigmoid entry in Q16 for table index i of a table with depth entries.
    function automatic logic [16:0] sigmoid_entry(input longint i, input longint depth);
        longint x;
        logic [63:0] t;
        logic [63:0] n;
        logic [63:0] f;
        logic [63:0] sum;
        logic [63:0] term;
        logic [63:0] den;
        logic [63:0] s;
        x = longint'(udiv(64'(12 * i) << 24, 64'(depth))) - (longint'(3) << 24);
        t = (x < 0) ? 64'(-x) : 64'(x);
        n = t >> 24;
        f = t & 64'hFF_FFFF;
        sum = 64'd1 << 30;
        term = 64'd1 << 30;
        for (int k = 1; k <= 12; k++)
        begin
            term = udiv((term * f) >> 24, 64'(k));
            if ((k & 1) != 0)
                sum = sum - term;
            else
                sum = sum + term;
        end
        for (int k = 0; k < 16; k++)
        begin
            if (64'(k) < n)
                sum = (sum * 64'(EXP_M1_Q30)) >> 30;
        end
        den = (64'd1 << 30) + sum;
        s = udiv((64'd1 << 46) + (den >> 1), den);
        if (x < 0)
            s = 64'd65536 - s;
        return s[16:0];
    endfunction

endpackage

FILE: hdl/gtpvc_if.sv
interface gtpvc_pose_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] robot_x;
    logic signed [15:0] robot_y;
    logic signed [14:0] robot_heading;
    logic signed [15:0] goal_x;
    logic signed [15:0] goal_y;
    logic signed [14:0] goal_heading;

    modport source (output valid, robot_x, robot_y, robot_heading, goal_x, goal_y,
                    goal_heading, input ready);
    modport sink (input valid, robot_x, robot_y, robot_heading, goal_x, goal_y,
                  goal_heading, output ready);
endinterface

interface gtpvc_cmd_if;
    logic               valid;
    logic               ready;
    logic signed [12:0] speed_forward;
    logic signed [12:0] speed_sideways;
    logic signed [16:0] turn_rate;
    logic [1:0]         drive_mode;

    modport source (output valid, speed_forward, speed_sideways, turn_rate, drive_mode,
                    input ready);
    modport sink (input valid, speed_forward, speed_sideways, turn_rate, drive_mode,
                  output ready);
endinterface

interface gtpvc_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [gtpvc_pkg::CFG_INDEX_W-1:0]   index;
    logic [gtpvc_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: hdl/gtpvc_cordic.sv
module gtpvc_cordic #(
    parameter int STEPS = gtpvc_pkg::CORDIC_STEPS_DEF,
    parameter int LAT   = gtpvc_pkg::SQRT_STEPS
) (
    input  logic               clk,
    input  logic               en,
    input  logic signed [32:0] z_in,
    output logic signed [31:0] cos_out,
    output logic signed [31:0] sin_out
);

    logic signed [31:0] x_reg [LAT];
    logic signed [31:0] y_reg [LAT];
    logic signed [32:0] z_reg [LAT];

    for (genvar k = 0; k < LAT; k++)
    begin : g_stage
        logic signed [31:0] x_in;
        logic signed [31:0] y_in;
        logic signed [32:0] z_cur;
        logic signed [31:0] x_next;
        logic signed [31:0] y_next;
        logic signed [32:0] z_next;

        if (k == 0)
        begin : g_first
            assign x_in  = 32'(gtpvc_pkg::CORDIC_GAIN_INV);
            assign y_in  = '0;
            assign z_cur = z_in;
        end
        else
        begin : g_chain
            assign x_in  = x_reg[k-1];
            assign y_in  = y_reg[k-1];
            assign z_cur = z_reg[k-1];
        end

        if (k < STEPS)
        begin : g_rot
            always_comb
            begin
                if (z_cur >= 0)
                begin
                    x_next = x_in - (y_in >>> k);
                    y_next = y_in + (x_in >>> k);
                    z_next = z_cur - $signed({1'b0, gtpvc_pkg::ATAN_Q30[k]});
                end
                else
                begin
                    x_next = x_in + (y_in >>> k);
                    y_next = y_in - (x_in >>> k);
                    z_next = z_cur + $signed({1'b0, gtpvc_pkg::ATAN_Q30[k]});
                end
            end
        end
        else
        begin : g_pad
            assign x_next = x_in;
            assign y_next = y_in;
            assign z_next = z_cur;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[k] <= x_next;
                y_reg[k] <= y_next;
                z_reg[k] <= z_next;
            end
        end
    end

    assign cos_out = x_reg[LAT-1];
    assign sin_out = y_reg[LAT-1];

endmodule

FILE: hdl/gtpvc_isqrt.sv
module gtpvc_isqrt #(
    parameter int LAT = gtpvc_pkg::SQRT_STEPS
) (
    input  logic        clk,
    input  logic        en,
    input  logic [32:0] v_in,
    output logic [16:0] root
);

    logic [34:0] rem_reg  [LAT];
    logic [34:0] root_reg [LAT];

    for (genvar k = 0; k < LAT; k++)
    begin : g_stage
        logic [34:0] rem_in;
        logic [34:0] root_in;
        logic [34:0] rem_next;
        logic [34:0] root_next;

        if (k == 0)
        begin : g_first
            assign rem_in  = 35'(v_in);
            assign root_in = '0;
        end
        else
        begin : g_chain
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
        end

        if (k < gtpvc_pkg::SQRT_STEPS)
        begin : g_digit
            localparam logic [34:0] BIT = 35'd1 << (2 * (gtpvc_pkg::SQRT_STEPS - 1 - k));
            logic [34:0] trial;
            assign trial = root_in + BIT;
            always_comb
            begin
                if (rem_in >= trial)
                begin
                    rem_next  = rem_in - trial;
                    root_next = (root_in >> 1) + BIT;
                end
                else
                begin
                    rem_next  = rem_in;
                    root_next = root_in >> 1;
                end
            end
        end
        else
        begin : g_pad
            assign rem_next  = rem_in;
            assign root_next = root_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
            end
        end
    end

    assign root = root_reg[LAT-1][16:0];

endmodule

FILE: hdl/go_to_pose_velocity_controller_unit.sv
// Go-to-pose velocity controller. Each pose beat on the pose channel (robot
// pose and goal pose) yields exactly one command beat on the cmd channel, in
// order. The block is a single pipeline that accepts one pose per clock while
// it is not held (see the last sentences), and it is built as follows: three
// stages form the errors and the squared distance, then the CORDIC rotator and
// the 17-step square root run side by side, padded to the same depth, and
// four more stages apply the rotation, the sigmoid table, the speed scaling
// and the clamps. The whole pipeline advances together; it holds only while a
// finished command sits in the output register and the sink is not ready.
// Configuration writes (stop_distance at index 0, speed_limit at index 1) are
// always accepted and should be made while no pose is in flight.
module go_to_pose_velocity_controller_unit #(
    parameter int CORDIC_STEPS        = gtpvc_pkg::CORDIC_STEPS_DEF,
    parameter int SIGMOID_TABLE_DEPTH = gtpvc_pkg::SIG_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    gtpvc_pose_if.sink  pose,
    gtpvc_cmd_if.source cmd,
    gtpvc_cfg_if.sink   cfg
);

    // Depth of the shared rotator and square-root section.
    localparam int UNIT_LAT = (CORDIC_STEPS > gtpvc_pkg::SQRT_STEPS) ?
                              CORDIC_STEPS : gtpvc_pkg::SQRT_STEPS;
    localparam int IDX_W    = $clog2(SIGMOID_TABLE_DEPTH);
    localparam int PROD_W   = 17 + IDX_W + 1;

    // ------------------------------------------------------------------
    // Configuration registers. The squared stop distance is kept ready so
    // that the drive decision is a single compare.
    // ------------------------------------------------------------------
    logic [14:0] stop_distance_reg;
    logic [11:0] speed_limit_reg;
    logic [29:0] stop_sq_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stop_distance_reg <= 15'd512;
            speed_limit_reg   <= 12'd1024;
            stop_sq_reg       <= 30'd262144;
        end
        else
        begin
            if (cfg.valid && cfg.index == gtpvc_pkg::REG_STOP_DISTANCE)
                stop_distance_reg <= cfg.data[14:0];
            if (cfg.valid && cfg.index == gtpvc_pkg::REG_SPEED_LIMIT)
                speed_limit_reg <= cfg.data[11:0];
            stop_sq_reg <= 30'(stop_distance_reg) * 30'(stop_distance_reg);
        end
    end

    // Global advance: every stage moves when the output register is free or
    // being emptied in this cycle.
    logic out_valid_reg;
    logic adv;

    assign adv        = !out_valid_reg || cmd.ready;
    assign pose.ready = adv;

    // ------------------------------------------------------------------
    // Stage 1: position error, wrapped heading error and the folded robot
    // heading. When the heading is folded by pi the signs of sin and cos
    // flip; that is carried by negating the error vector used for rotation.
    // ------------------------------------------------------------------
    logic signed [16:0] ex_c;
    logic signed [16:0] ey_c;
    logic signed [15:0] eh_raw;
    logic signed [15:0] eh_wrap;
    logic signed [15:0] rh_wrap;
    logic signed [15:0] rh_fold;
    logic               fold_neg;

    always_comb
    begin
        ex_c   = 17'(pose.goal_x) - 17'(pose.robot_x);
        ey_c   = 17'(pose.goal_y) - 17'(pose.robot_y);
        eh_raw = 16'(pose.goal_heading) - 16'(pose.robot_heading);
        if (eh_raw > 16'sd12868)
            eh_wrap = eh_raw - 16'sd25736;
        else if (eh_raw < -16'sd12868)
            eh_wrap = eh_raw + 16'sd25736;
        else
            eh_wrap = eh_raw;

        rh_wrap = 16'(pose.robot_heading);
        if (rh_wrap > 16'sd12868)
            rh_wrap = rh_wrap - 16'sd25736;
        else if (rh_wrap < -16'sd12868)
            rh_wrap = rh_wrap + 16'sd25736;

        fold_neg = 1'b0;
        rh_fold  = rh_wrap;
        if (rh_wrap > 16'sd6434)
        begin
            rh_fold  = rh_wrap - 16'sd12868;
            fold_neg = 1'b1;
        end
        else if (rh_wrap < -16'sd6434)
        begin
            rh_fold  = rh_wrap + 16'sd12868;
            fold_neg = 1'b1;
        end
    end

    logic               s1_valid_reg;
    logic signed [16:0] s1_ex_reg;
    logic signed [16:0] s1_ey_reg;
    logic signed [14:0] s1_eh_reg;
    logic signed [32:0] s1_z_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_ex_reg <= fold_neg ? -ex_c : ex_c;
            s1_ey_reg <= fold_neg ? -ey_c : ey_c;
            s1_eh_reg <= eh_wrap[14:0];
            s1_z_reg  <= 33'(rh_fold) <<< 18;
        end
    end

    // Stage 2: squares of the error components (negation leaves them equal).
    logic               s2_valid_reg;
    logic signed [16:0] s2_ex_reg;
    logic signed [16:0] s2_ey_reg;
    logic signed [14:0] s2_eh_reg;
    logic signed [32:0] s2_z_reg;
    logic [31:0]        s2_sqx_reg;
    logic [31:0]        s2_sqy_reg;
    logic signed [33:0] sqx_full;
    logic signed [33:0] sqy_full;

    assign sqx_full = 34'(s1_ex_reg) * 34'(s1_ex_reg);
    assign sqy_full = 34'(s1_ey_reg) * 34'(s1_ey_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_ex_reg  <= s1_ex_reg;
            s2_ey_reg  <= s1_ey_reg;
            s2_eh_reg  <= s1_eh_reg;
            s2_z_reg   <= s1_z_reg;
            s2_sqx_reg <= sqx_full[31:0];
            s2_sqy_reg <= sqy_full[31:0];
        end
    end

    // Stage 3: squared distance and the drive decision.
    logic               s3_valid_reg;
    logic signed [16:0] s3_ex_reg;
    logic signed [16:0] s3_ey_reg;
    logic signed [14:0] s3_eh_reg;
    logic signed [32:0] s3_z_reg;
    logic [32:0]        s3_sq_reg;
    logic               s3_drive_reg;
    logic [32:0]        sq_sum;

    assign sq_sum = 33'(s2_sqx_reg) + 33'(s2_sqy_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_ex_reg    <= s2_ex_reg;
            s3_ey_reg    <= s2_ey_reg;
            s3_eh_reg    <= s2_eh_reg;
            s3_z_reg     <= s2_z_reg;
            s3_sq_reg    <= sq_sum;
            s3_drive_reg <= sq_sum > 33'(stop_sq_reg);
        end
    end

    // ------------------------------------------------------------------
    // Rotator and square root, with the item's other fields carried on a
    // shift line of the same depth.
    // ------------------------------------------------------------------
    logic signed [31:0] cos_q30;
    logic signed [31:0] sin_q30;
    logic [16:0]        dist_root;

    gtpvc_cordic #(
        .STEPS (CORDIC_STEPS),
        .LAT   (UNIT_LAT)
    ) u_cordic (
        .clk     (clk),
        .en      (adv),
        .z_in    (s3_z_reg),
        .cos_out (cos_q30),
        .sin_out (sin_q30)
    );

    gtpvc_isqrt #(
        .LAT (UNIT_LAT)
    ) u_isqrt (
        .clk  (clk),
        .en   (adv),
        .v_in (s3_sq_reg),
        .root (dist_root)
    );

    logic               p_valid_reg [UNIT_LAT];
    logic signed [16:0] p_ex_reg    [UNIT_LAT];
    logic signed [16:0] p_ey_reg    [UNIT_LAT];
    logic signed [14:0] p_eh_reg    [UNIT_LAT];
    logic               p_drive_reg [UNIT_LAT];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_ex_reg[0]    <= s3_ex_reg;
            p_ey_reg[0]    <= s3_ey_reg;
            p_eh_reg[0]    <= s3_eh_reg;
            p_drive_reg[0] <= s3_drive_reg;
            for (int k = 1; k < UNIT_LAT; k++)
            begin
                p_ex_reg[k]    <= p_ex_reg[k-1];
                p_ey_reg[k]    <= p_ey_reg[k-1];
                p_eh_reg[k]    <= p_eh_reg[k-1];
                p_drive_reg[k] <= p_drive_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: rotation products and the sigmoid table index.
    // ------------------------------------------------------------------
    logic               s4_valid_reg;
    logic signed [14:0] s4_eh_reg;
    logic               s4_drive_reg;
    logic signed [48:0] s4_exc_reg;
    logic signed [48:0] s4_eys_reg;
    logic signed [48:0] s4_eyc_reg;
    logic signed [48:0] s4_exs_reg;
    logic [IDX_W-1:0]   s4_idx_reg;
    logic               s4_sat_reg;
    logic [PROD_W-1:0]  idx_full;

    assign idx_full = (PROD_W'(dist_root) * PROD_W'(SIGMOID_TABLE_DEPTH)) >> 11;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_eh_reg    <= p_eh_reg[UNIT_LAT-1];
            s4_drive_reg <= p_drive_reg[UNIT_LAT-1];
            s4_exc_reg   <= 49'(p_ex_reg[UNIT_LAT-1]) * 49'(cos_q30);
            s4_eys_reg   <= 49'(p_ey_reg[UNIT_LAT-1]) * 49'(sin_q30);
            s4_eyc_reg   <= 49'(p_ey_reg[UNIT_LAT-1]) * 49'(cos_q30);
            s4_exs_reg   <= 49'(p_ex_reg[UNIT_LAT-1]) * 49'(sin_q30);
            s4_idx_reg   <= idx_full[IDX_W-1:0];
            s4_sat_reg   <= idx_full >= PROD_W'(SIGMOID_TABLE_DEPTH);
        end
    end

    // Sigmoid table, built at elaboration.
    logic [16:0] sig_rom [SIGMOID_TABLE_DEPTH];

    for (genvar i = 0; i < SIGMOID_TABLE_DEPTH; i++)
    begin : g_rom
        localparam logic [16:0] ENTRY = gtpvc_pkg::sigmoid_entry(longint'(i),
                                                                longint'(SIGMOID_TABLE_DEPTH));
        assign sig_rom[i] = ENTRY;
    end

    // Stage 5: robot-frame error and the sigmoid gain.
    logic               s5_valid_reg;
    logic signed [14:0] s5_eh_reg;
    logic               s5_drive_reg;
    logic signed [35:0] s5_fx_reg;
    logic signed [35:0] s5_fy_reg;
    logic [16:0]        s5_sig_reg;
    logic signed [49:0] fx_sum;
    logic signed [49:0] fy_sum;

    assign fx_sum = 50'(s4_exc_reg) + 50'(s4_eys_reg);
    assign fy_sum = 50'(s4_eyc_reg) - 50'(s4_exs_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s5_eh_reg    <= s4_eh_reg;
            s5_drive_reg <= s4_drive_reg;
            s5_fx_reg    <= 36'(fx_sum >>> 14);
            s5_fy_reg    <= 36'(fy_sum >>> 14);
            s5_sig_reg   <= s4_sat_reg ? 17'd65536 : sig_rom[s4_idx_reg];
        end
    end

    // Stage 6: speed scaling products.
    logic               s6_valid_reg;
    logic signed [14:0] s6_eh_reg;
    logic               s6_drive_reg;
    logic signed [53:0] s6_pf_reg;
    logic signed [53:0] s6_ps_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s6_eh_reg    <= s5_eh_reg;
            s6_drive_reg <= s5_drive_reg;
            s6_pf_reg    <= 54'(s5_fx_reg) * 54'($signed({1'b0, s5_sig_reg}));
            s6_ps_reg    <= 54'(s5_fy_reg) * 54'($signed({1'b0, s5_sig_reg}));
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: rounding, clamps and mode selection into the output register.
    // ------------------------------------------------------------------
    logic signed [54:0] fwd_sum;
    logic signed [54:0] side_sum;
    logic signed [22:0] fwd_raw;
    logic signed [22:0] side_raw;
    logic signed [22:0] lim_hi;
    logic signed [22:0] lim_half;
    logic signed [22:0] fwd_c;
    logic signed [22:0] side_c;
    logic signed [17:0] turn4;
    logic signed [17:0] turn_c;
    logic signed [12:0] fwd_next;
    logic signed [12:0] side_next;
    logic signed [16:0] turn_next;
    gtpvc_pkg::drive_mode_t mode_next;

    always_comb
    begin
        fwd_sum  = 55'(s6_pf_reg) + (55'sd1 <<< 31);
        side_sum = 55'(s6_ps_reg) + (55'sd1 <<< 31);
        fwd_raw  = 23'(fwd_sum >>> 32);
        side_raw = 23'(side_sum >>> 32);
        lim_hi   = $signed(23'(speed_limit_reg));
        lim_half = $signed(23'(speed_limit_reg[11:1]));

        if (fwd_raw < -lim_half)
            fwd_c = -lim_half;
        else if (fwd_raw > lim_hi)
            fwd_c = lim_hi;
        else
            fwd_c = fwd_raw;

        if (side_raw < -lim_half)
            side_c = -lim_half;
        else if (side_raw > lim_half)
            side_c = lim_half;
        else
            side_c = side_raw;

        turn4 = 18'(s6_eh_reg) <<< 2;
        if (turn4 > 18'sd4915)
            turn_c = 18'sd4915;
        else if (turn4 < -18'sd4915)
            turn_c = -18'sd4915;
        else
            turn_c = turn4;

        if (s6_drive_reg)
        begin
            fwd_next  = fwd_c[12:0];
            side_next = side_c[12:0];
            turn_next = turn_c[16:0];
            mode_next = gtpvc_pkg::MODE_DRIVE;
        end
        else if (s6_eh_reg > 15'sd819 || s6_eh_reg < -15'sd819)
        begin
            fwd_next  = '0;
            side_next = '0;
            turn_next = turn4[16:0];
            mode_next = gtpvc_pkg::MODE_TURN;
        end
        else
        begin
            fwd_next  = '0;
            side_next = '0;
            turn_next = '0;
            mode_next = gtpvc_pkg::MODE_STOP;
        end
    end

    logic signed [12:0]     fwd_reg;
    logic signed [12:0]     side_reg;
    logic signed [16:0]     turn_reg;
    gtpvc_pkg::drive_mode_t mode_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fwd_reg  <= fwd_next;
            side_reg <= side_next;
            turn_reg <= turn_next;
            mode_reg <= mode_next;
        end
    end

    // Valid bits travel alongside the data through every stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            for (int k = 0; k < UNIT_LAT; k++)
                p_valid_reg[k] <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            s6_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg   <= pose.valid;
            s2_valid_reg   <= s1_valid_reg;
            s3_valid_reg   <= s2_valid_reg;
            p_valid_reg[0] <= s3_valid_reg;
            for (int k = 1; k < UNIT_LAT; k++)
                p_valid_reg[k] <= p_valid_reg[k-1];
            s4_valid_reg   <= p_valid_reg[UNIT_LAT-1];
            s5_valid_reg   <= s4_valid_reg;
            s6_valid_reg   <= s5_valid_reg;
            out_valid_reg  <= s6_valid_reg;
        end
    end

    assign cmd.valid          = out_valid_reg;
    assign cmd.speed_forward  = fwd_reg;
    assign cmd.speed_sideways = side_reg;
    assign cmd.turn_rate      = turn_reg;
    assign cmd.drive_mode     = mode_reg;

endmodule

FILE: tb/go_to_pose_velocity_controller_unit_tb.sv
`timescale 1ns / 100ps

module go_to_pose_velocity_controller_unit_tb;

    // A register index that the block does not implement; writes to it must be ignored.
    localparam logic [gtpvc_pkg::CFG_INDEX_W-1:0] REG_UNMAPPED = 4'd9;
    // Long enough for the pipeline to empty at the default parameters, with headroom.
    localparam int SETTLE_CYCLES = 48;
    // No beat on any channel for this many cycles means the block has hung.
    localparam int STALL_LIMIT = 4000;

    typedef struct {
        logic signed [15:0] robot_x;
        logic signed [15:0] robot_y;
        logic signed [14:0] robot_heading;
        logic signed [15:0] goal_x;
        logic signed [15:0] goal_y;
        logic signed [14:0] goal_heading;
    } pose_beat_t;

    typedef struct {
        logic signed [12:0]     speed_forward;
        logic signed [12:0]     speed_sideways;
        logic signed [16:0]     turn_rate;
        gtpvc_pkg::drive_mode_t drive_mode;
    } command_t;

    logic clk;
    logic rst_n;

    gtpvc_pose_if pose_if ();
    gtpvc_cmd_if  cmd_if ();
    gtpvc_cfg_if  cfg_if ();

    go_to_pose_velocity_controller_unit u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .pose  (pose_if.sink),
        .cmd   (cmd_if.source),
        .cfg   (cfg_if.sink)
    );

    // Our own copy of the two registers, updated on every accepted write beat.
    longint stop_dist_q;
    longint speed_limit_q;

    // Speed scale per table slot, Q16, built once at start-up.
    longint speed_scale_q16 [gtpvc_pkg::SIG_DEPTH_DEF];

    command_t pending_commands [$];
    int       failures;
    int       quiet_cycles;
    bit       pose_gaps_on;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    // All inputs are at a known value from time zero.
    initial
    begin
        rst_n = 1'b0;
        pose_if.valid = 1'b0;
        pose_if.robot_x = '0;
        pose_if.robot_y = '0;
        pose_if.robot_heading = '0;
        pose_if.goal_x = '0;
        pose_if.goal_y = '0;
        pose_if.goal_heading = '0;
        cfg_if.valid = 1'b0;
        cfg_if.index = '0;
        cfg_if.data = '0;
        cmd_if.ready = 1'b0;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    function automatic longint wrap_heading(input longint a);
        longint w;
        w = a;
        while (w > gtpvc_pkg::ANG_PI)
            w = w - gtpvc_pkg::ANG_2PI;
        while (w < -gtpvc_pkg::ANG_PI)
            w = w + gtpvc_pkg::ANG_2PI;
        return w;
    endfunction

    function automatic longint int_sqrt(input longint v);
        longint root;
        longint lo;
        longint hi;
        longint mid;
        lo = 0;
        hi = 131072;
        // Binary search for the largest root whose square does not exceed v.
        while (lo < hi)
        begin
            mid = (lo + hi + 1) / 2;
            if (mid * mid <= v)
                lo = mid;
            else
                hi = mid - 1;
        end
        root = lo;
        return root;
    endfunction

    // The logistic 1/(1+exp(-x)) at the start of table slot i, with exp(-|x|) built
    // from a truncated Taylor series on the fractional part and whole factors of e^-1.
    function automatic longint logistic_q16(input longint i);
        longint x;
        longint mag;
        longint whole;
        longint frac;
        longint acc;
        longint term;
        longint den;
        longint val;
        x = ((12 * i) << 24) / gtpvc_pkg::SIG_DEPTH_DEF - (longint'(3) << 24);
        mag = (x < 0) ? -x : x;
        whole = mag >> 24;
        frac = mag & 64'hFF_FFFF;
        acc = longint'(1) << 30;
        term = longint'(1) << 30;
        for (int k = 1; k <= 12; k++)
        begin
            term = ((term * frac) >> 24) / k;
            if (k % 2 == 1)
                acc = acc - term;
            else
                acc = acc + term;
        end
        for (longint k = 0; k < whole; k++)
            acc = (acc * gtpvc_pkg::EXP_M1_Q30) >> 30;
        den = (longint'(1) << 30) + acc;
        val = ((longint'(1) << 46) + (den >> 1)) / den;
        return (x < 0) ? 65536 - val : val;
    endfunction

    // Rotation by CORDIC in Q30 after folding the heading into [-pi/2, pi/2].
    task automatic heading_cos_sin(input longint heading, output longint c, output longint s);
        longint h;
        longint vx;
        longint vy;
        longint z;
        longint nx;
        bit     flip;
        h = wrap_heading(heading);
        flip = 1'b0;
        if (h > gtpvc_pkg::ANG_HALF_PI)
        begin
            h = h - gtpvc_pkg::ANG_PI;
            flip = 1'b1;
        end
        else if (h < -gtpvc_pkg::ANG_HALF_PI)
        begin
            h = h + gtpvc_pkg::ANG_PI;
            flip = 1'b1;
        end
        vx = gtpvc_pkg::CORDIC_GAIN_INV;
        vy = 0;
        z = h * 262144;
        for (int k = 0; k < gtpvc_pkg::CORDIC_STEPS_DEF && k < 24; k++)
        begin
            if (z >= 0)
            begin
                nx = vx - (vy >>> k);
                vy = vy + (vx >>> k);
                z = z - longint'(gtpvc_pkg::ATAN_Q30[k]);
            end
            else
            begin
                nx = vx + (vy >>> k);
                vy = vy - (vx >>> k);
                z = z + longint'(gtpvc_pkg::ATAN_Q30[k]);
            end
            vx = nx;
        end
        c = flip ? -vx : vx;
        s = flip ? -vy : vy;
    endtask

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    task automatic predict_command(input pose_beat_t p, output command_t cmd);
        longint ex;
        longint ey;
        longint eh;
        longint dist_sq;
        longint dist_len;
        longint slot;
        longint scale;
        longint c;
        longint s;
        longint fx;
        longint fy;
        longint fwd;
        longint side;
        longint turn;
        longint half;
        gtpvc_pkg::drive_mode_t mode;
        ex = longint'(p.goal_x) - longint'(p.robot_x);
        ey = longint'(p.goal_y) - longint'(p.robot_y);
        eh = wrap_heading(longint'(p.goal_heading) - longint'(p.robot_heading));
        dist_sq = ex * ex + ey * ey;
        fwd = 0;
        side = 0;
        turn = 0;
        if (dist_sq > stop_dist_q * stop_dist_q)
        begin
            dist_len = int_sqrt(dist_sq);
            slot = dist_len * gtpvc_pkg::SIG_DEPTH_DEF / 2048;
            scale = (slot >= gtpvc_pkg::SIG_DEPTH_DEF) ? 65536 : speed_scale_q16[slot];
            heading_cos_sin(longint'(p.robot_heading), c, s);
            fx = (ex * c + ey * s) >>> 14;
            fy = (ey * c - ex * s) >>> 14;
            half = speed_limit_q >> 1;
            fwd = clip((fx * scale + (longint'(1) << 31)) >>> 32, -half, speed_limit_q);
            side = clip((fy * scale + (longint'(1) << 31)) >>> 32, -half, half);
            turn = clip(eh * 4, -gtpvc_pkg::TURN_CAP, gtpvc_pkg::TURN_CAP);
            mode = gtpvc_pkg::MODE_DRIVE;
        end
        else if (eh > gtpvc_pkg::TURN_DEADBAND || eh < -gtpvc_pkg::TURN_DEADBAND)
        begin
            // Close enough to the goal: rotate on the spot, with no turn rate limit.
            turn = eh * 4;
            mode = gtpvc_pkg::MODE_TURN;
        end
        else
        begin
            mode = gtpvc_pkg::MODE_STOP;
        end
        cmd.speed_forward = fwd[12:0];
        cmd.speed_sideways = side[12:0];
        cmd.turn_rate = turn[16:0];
        cmd.drive_mode = mode;
    endtask

    // ------------------------------------------------------------------
    // Checking of command beats, sampled on the rising edge.
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        command_t want;
        if (rst_n && cmd_if.valid && cmd_if.ready)
        begin
            if (pending_commands.size() == 0)
            begin
                $display("%0t: command beat with nothing expected (fwd %0d side %0d turn %0d mode %0d)",
                         $time, cmd_if.speed_forward, cmd_if.speed_sideways,
                         cmd_if.turn_rate, cmd_if.drive_mode);
                failures++;
            end
            else
            begin
                want = pending_commands.pop_front();
                if (cmd_if.speed_forward !== want.speed_forward)
                begin
                    $display("%0t: speed_forward expected %0d actual %0d", $time,
                             want.speed_forward, cmd_if.speed_forward);
                    failures++;
                end
                if (cmd_if.speed_sideways !== want.speed_sideways)
                begin
                    $display("%0t: speed_sideways expected %0d actual %0d", $time,
                             want.speed_sideways, cmd_if.speed_sideways);
                    failures++;
                end
                if (cmd_if.turn_rate !== want.turn_rate)
                begin
                    $display("%0t: turn_rate expected %0d actual %0d", $time,
                             want.turn_rate, cmd_if.turn_rate);
                    failures++;
                end
                if (cmd_if.drive_mode !== want.drive_mode)
                begin
                    $display("%0t: drive_mode expected %0d actual %0d", $time,
                             want.drive_mode, cmd_if.drive_mode);
                    failures++;
                end
            end
        end
    end

    // Counts cycles in which no beat moves on any channel.
    always @(posedge clk)
    begin
        if ((pose_if.valid && pose_if.ready) || (cmd_if.valid && cmd_if.ready) ||
            (cfg_if.valid && cfg_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        quiet_cycles = 0;
        wait (rst_n === 1'b1);
        while (quiet_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    // The command sink stalls at random: mostly in short bursts, now and then for a
    // long stretch, and with long runs of steady readiness in between.
    initial
    begin
        int hold;
        int pick;
        hold = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold > 0)
                hold--;
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 50)
                begin
                    cmd_if.ready = 1'b1;
                    hold = $urandom_range(0, 40);
                end
                else if (pick < 92)
                begin
                    cmd_if.ready = 1'b0;
                    hold = $urandom_range(0, 3);
                end
                else
                begin
                    cmd_if.ready = 1'b0;
                    hold = $urandom_range(15, 80);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Called at a falling edge; returns at a falling edge with valid still high, so that
    // a following beat can go out back to back without valid dropping.
    task automatic send_pose(input pose_beat_t p);
        int gap;
        int pick;
        command_t cmd;
        gap = 0;
        if (pose_gaps_on)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                gap = 0;
            else if (pick < 92)
                gap = $urandom_range(1, 3);
            else
                gap = $urandom_range(10, 60);
        end
        if (gap > 0)
        begin
            pose_if.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        pose_if.valid = 1'b1;
        pose_if.robot_x = p.robot_x;
        pose_if.robot_y = p.robot_y;
        pose_if.robot_heading = p.robot_heading;
        pose_if.goal_x = p.goal_x;
        pose_if.goal_y = p.goal_y;
        pose_if.goal_heading = p.goal_heading;
        forever
        begin
            @(posedge clk);
            if (pose_if.ready)
                break;
        end
        predict_command(p, cmd);
        pending_commands.push_back(cmd);
        @(negedge clk);
    endtask

    task automatic drop_pose_valid();
        pose_if.valid = 1'b0;
    endtask

    // Wait for every outstanding command and then let the pipeline settle, so that
    // a register write cannot touch a pose in flight.
    task automatic wait_until_drained();
        drop_pose_valid();
        while (pending_commands.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(input logic [gtpvc_pkg::CFG_INDEX_W-1:0] idx,
                                  input logic [gtpvc_pkg::CFG_DATA_W-1:0] value);
        cfg_if.valid = 1'b1;
        cfg_if.index = idx;
        cfg_if.data = value;
        forever
        begin
            @(posedge clk);
            if (cfg_if.ready)
                break;
        end
        if (idx == gtpvc_pkg::REG_STOP_DISTANCE)
            stop_dist_q = longint'(value) & 64'h7FFF;
        else if (idx == gtpvc_pkg::REG_SPEED_LIMIT)
            speed_limit_q = longint'(value) & 64'hFFF;
        @(negedge clk);
        cfg_if.valid = 1'b0;
    endtask

    task automatic set_limits(input int stop_d, input int v_max);
        wait_until_drained();
        write_register(gtpvc_pkg::REG_STOP_DISTANCE, gtpvc_pkg::CFG_DATA_W'(stop_d));
        write_register(gtpvc_pkg::REG_SPEED_LIMIT, gtpvc_pkg::CFG_DATA_W'(v_max));
    endtask

    function automatic pose_beat_t make_pose(input int rx, input int ry, input int rh,
                                             input int gx, input int gy, input int gh);
        pose_beat_t p;
        p.robot_x = 16'(rx);
        p.robot_y = 16'(ry);
        p.robot_heading = 15'(rh);
        p.goal_x = 16'(gx);
        p.goal_y = 16'(gy);
        p.goal_heading = 15'(gh);
        return p;
    endfunction

    function automatic logic [14:0] random_heading();
        // Mostly legal headings, sometimes any bit pattern so that the wrap gets used.
        if ($urandom_range(0, 9) == 0)
            return 15'($urandom);
        return 15'($urandom_range(0, 2 * gtpvc_pkg::ANG_PI) - gtpvc_pkg::ANG_PI);
    endfunction

    // A pose whose goal sits at a chosen kind of range from the robot, so that stopping,
    // turning on the spot, the sloped part of the sigmoid and its saturation all occur.
    function automatic pose_beat_t random_pose();
        pose_beat_t p;
        int reach;
        int pick;
        p.robot_x = 16'($urandom);
        p.robot_y = 16'($urandom);
        p.robot_heading = random_heading();
        pick = $urandom_range(0, 99);
        if (pick < 25)
            reach = 3 * int'(stop_dist_q) / 2 + 8;
        else if (pick < 75)
            reach = 2300;
        else
            reach = -1;
        if (reach < 0)
        begin
            p.goal_x = 16'($urandom);
            p.goal_y = 16'($urandom);
        end
        else
        begin
            p.goal_x = 16'(int'(p.robot_x) + $urandom_range(0, 2 * reach) - reach);
            p.goal_y = 16'(int'(p.robot_y) + $urandom_range(0, 2 * reach) - reach);
        end
        // Now and then let the heading error sit close to the turn dead band, as it does near the goal.
        if ($urandom_range(0, 3) == 0)
            p.goal_heading = 15'(int'(p.robot_heading) + $urandom_range(0, 2000) - 1000);
        else
            p.goal_heading = random_heading();
        return p;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Boundaries of the decision logic and the field extremes, at the reset settings.
    task automatic test_directed_poses();
        // Robot on the goal, headings equal: stopped.
        send_pose(make_pose(0, 0, 0, 0, 0, 0));
        // Heading error just inside the dead band, then just outside it with both signs.
        send_pose(make_pose(100, 100, 0, 100, 100, gtpvc_pkg::TURN_DEADBAND));
        send_pose(make_pose(100, 100, 0, 100, 100, gtpvc_pkg::TURN_DEADBAND + 1));
        send_pose(make_pose(100, 100, 0, 100, 100, -gtpvc_pkg::TURN_DEADBAND - 1));
        send_pose(make_pose(-5, 7, gtpvc_pkg::ANG_PI, -5, 7, -gtpvc_pkg::ANG_PI));
        // Distance exactly at the stop threshold, then one step past it.
        send_pose(make_pose(0, 0, 0, 512, 0, 3000));
        send_pose(make_pose(0, 0, 0, 513, 0, 3000));
        send_pose(make_pose(0, 0, 0, 0, -513, -3000));
        // Widest position errors; the first and last also put the turn rate at its clamp.
        send_pose(make_pose(-32768, -32768, 0, 32767, 32767, gtpvc_pkg::ANG_PI));
        send_pose(make_pose(32767, 32767, gtpvc_pkg::ANG_PI, -32768, -32768,
                            -gtpvc_pkg::ANG_PI));
        send_pose(make_pose(32767, -32768, -gtpvc_pkg::ANG_PI, -32768, 32767, 0));
        // Goal behind and to the side, on the sloped part of the speed profile.
        send_pose(make_pose(0, 0, 0, -1500, 0, 0));
        send_pose(make_pose(0, 0, 0, 0, 1000, 0));
        send_pose(make_pose(0, 0, gtpvc_pkg::ANG_HALF_PI, 1000, 0, 0));
        send_pose(make_pose(0, 0, gtpvc_pkg::ANG_HALF_PI + 1, 700, 700, 0));
        send_pose(make_pose(0, 0, -gtpvc_pkg::ANG_HALF_PI - 1, -700, 700, 0));
        // Heading patterns far outside +-pi, which the block wraps.
        send_pose(make_pose(0, 0, -16384, 2047, 0, 16383));
        send_pose(make_pose(0, 0, 16383, 0, 2048, -16384));
        send_pose(make_pose(10, 10, 16383, 10, 10, -16384));
        // Turn on the spot at the largest heading error.
        send_pose(make_pose(0, 0, -gtpvc_pkg::ANG_PI, 0, 0, 0));
        send_pose(make_pose(0, 0, gtpvc_pkg::ANG_PI, 0, 0, 0));
    endtask

    // Register extremes, masking of wide data, and an unmapped index.
    task automatic test_register_settings();
        set_limits(0, 0);
        send_pose(make_pose(0, 0, 0, 0, 0, 0));
        send_pose(make_pose(0, 0, 0, 1, 0, 900));
        send_pose(make_pose(0, 0, 0, -3000, 100, 0));
        set_limits(32767, 15'h7FFF);
        send_pose(make_pose(-32768, 0, 0, 0, 0, 5000));
        send_pose(make_pose(-32768, 0, 0, 32767, 0, 5000));
        send_pose(make_pose(0, 0, 0, -2000, 0, 0));
        wait_until_drained();
        write_register(REG_UNMAPPED, 15'd3);
        send_pose(make_pose(0, 0, 0, 3000, 0, 0));
        send_pose(make_pose(0, 0, 0, 0, 0, 820));
    endtask

    // Random poses over a series of settings, with the pose side idling in phases.
    task automatic test_random_poses();
        int stop_choices [6] = '{512, 0, 32767, 100, 2000, 700};
        int limit_choices [6] = '{1024, 4095, 0, 7, 2500, 300};
        for (int phase = 0; phase < 6; phase++)
        begin
            set_limits(stop_choices[phase], limit_choices[phase]);
            for (int n = 0; n < 210; n++)
            begin
                // Every third stretch of 50 poses runs back to back.
                pose_gaps_on = ((n / 50) % 3) != 1;
                send_pose(random_pose());
                // Once per phase, hold off until every command is back.
                if (n == 100)
                begin
                    drop_pose_valid();
                    while (pending_commands.size() != 0)
                        @(negedge clk);
                end
            end
        end
        pose_gaps_on = 1'b1;
    endtask

    initial
    begin
        failures = 0;
        pose_gaps_on = 1'b1;
        stop_dist_q = 512;
        speed_limit_q = 1024;
        for (int i = 0; i < gtpvc_pkg::SIG_DEPTH_DEF; i++)
            speed_scale_q16[i] = logistic_q16(i);

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed_poses();
        test_register_settings();
        test_random_poses();

        drop_pose_valid();
        while (pending_commands.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (failures == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: go_to_pose_velocity_controller_unit.f
hdl/gtpvc_pkg.sv
hdl/gtpvc_if.sv
hdl/gtpvc_cordic.sv
hdl/gtpvc_isqrt.sv
hdl/go_to_pose_velocity_controller_unit.sv
tb/go_to_pose_velocity_controller_unit_tb.sv
